[hw/rtl/euler_zyz_rotation_matrix_macros.svh]
// Assertion macros for the ZYZ Euler rotation matrix block.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef EULER_ZYZ_ROTATION_MATRIX_MACROS_SVH
`define EULER_ZYZ_ROTATION_MATRIX_MACROS_SVH
`define EZR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EZR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/ezr_pkg.sv]
// Package for the ZYZ Euler rotation matrix block.
// Holds the CORDIC constants and arctangent table; no dependencies.
`default_nettype none
package ezr_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int ZW = 33;
    localparam int XW = 34;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
        32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303,
        32'd651, 32'd325, 32'd162, 32'd81, 32'd40,
        32'd20, 32'd10, 32'd5, 32'd2, 32'd1
    };
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_rot;
endpackage
`default_nettype wire

[hw/rtl/ezr_cordic_cell.sv]
// One CORDIC rotation cell with a fixed shift; registers three rotations.
// Depends on ezr_pkg.
`default_nettype none
module ezr_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire ezr_pkg::t_rot   i_rot [3],
    output      ezr_pkg::t_rot   o_rot [3]
);
    import ezr_pkg::*;
    t_rot n_rot [3];
    t_rot r_rot [3];
    localparam logic signed [ZW-1:0] ANG = ZW'(signed'({1'b0, ATAN_TURN[STEP]}));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rot[k].flip = i_rot[k].flip;
            if (!i_rot[k].z[ZW-1]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> STEP);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> STEP);
                n_rot[k].z = i_rot[k].z - ANG;
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> STEP);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> STEP);
                n_rot[k].z = i_rot[k].z + ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end
    assign o_rot = r_rot;
endmodule
`default_nettype wire

[hw/rtl/ezr_mul_cell.sv]
// Rounded Q.FRAC product with a register after it.
// Depends on nothing but its ports.
`default_nettype none
module ezr_mul_cell #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic signed [FRAC_BITS+1:0] i_a,
    input  wire logic signed [FRAC_BITS+1:0] i_b,
    output      logic signed [FRAC_BITS+1:0] o_p
);
    localparam int PW = 2 * FRAC_BITS + 4;
    logic signed [PW-1:0] n_prod;
    logic signed [FRAC_BITS+1:0] r_p;
    always_comb begin
        n_prod = PW'(i_a) * PW'(i_b) + (PW'(1) <<< (FRAC_BITS - 1));
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (FRAC_BITS + 2)'(n_prod >>> FRAC_BITS);
        end
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

[hw/rtl/euler_zyz_rotation_matrix.sv]
// ZYZ Euler angles to rotation matrix, streaming.
// Input tdata: angle_alpha, angle_beta, angle_gamma (ANGLE_BITS each, from bit 0).
// Output tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22, FRAC_BITS+2 each, from bit 0.
// A row of 30 CORDIC cells turns all three angles at once, one register stage per cell;
// a rounding stage, two rows of multiplier cells, a sum stage and an output register follow.
// Throughput: one item per cycle while the receiver does not stall; the whole chain is pipelined.
// When the receiver stalls, the chain holds (all stages share one enable),
// and s_axis_tready drops whenever the output item is held.
// Reset clears the stage valid bits only; no clearing pass.
// Angles are taken as binary angles of 2^ANGLE_BITS per turn; sines and cosines
// and every element are clamped to +/- 2^FRAC_BITS.
// Depends on ezr_pkg, ezr_cordic_cell, ezr_mul_cell and the macro header.
`default_nettype none
`include "euler_zyz_rotation_matrix_macros.svh"
module euler_zyz_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    // angle_alpha, angle_beta, angle_gamma
    input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output      logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]  m_axis_tdata
);
    import ezr_pkg::*;
    localparam int OW = FRAC_BITS + 2;
    localparam int LAT = CORDIC_STEPS + 5;
    localparam int OUTW = ((9*OW+7)/8)*8;
    localparam logic signed [OW-1:0] ONE  = OW'(1) <<< FRAC_BITS;
    localparam logic signed [OW-1:0] MONE = -ONE;
    localparam int SH = 30 - FRAC_BITS;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[LAT-1];

    // prerotate into the right half plane
    t_rot c0 [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] t;
            t = {s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS], (32-ANGLE_BITS)'(0)};
            c0[k].flip = t[31] ^ t[30];
            if (c0[k].flip) begin
                t[31] = ~t[31];
            end
            c0[k].z = ZW'(signed'(t));
            c0[k].x = CORDIC_GAIN;
            c0[k].y = '0;
        end
    end

    t_rot chain [CORDIC_STEPS+1][3];
    assign chain[0] = c0;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ezr_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_rot(chain[g]), .o_rot(chain[g+1])
        );
    end

    function automatic logic signed [OW-1:0] clampw(input logic signed [XW:0] v);
        if (v > (XW+1)'(ONE)) clampw = ONE;
        else if (v < -(XW+1)'(ONE)) clampw = MONE;
        else clampw = OW'(v);
    endfunction

    // round and clamp: index 0 alpha, 1 beta, 2 gamma
    logic signed [OW-1:0] r_c [3];
    logic signed [OW-1:0] r_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [XW:0] xv, yv;
                xv = chain[CORDIC_STEPS][k].flip ? -(XW+1)'(chain[CORDIC_STEPS][k].x)
                                                 : (XW+1)'(chain[CORDIC_STEPS][k].x);
                yv = chain[CORDIC_STEPS][k].flip ? -(XW+1)'(chain[CORDIC_STEPS][k].y)
                                                 : (XW+1)'(chain[CORDIC_STEPS][k].y);
                r_c[k] <= clampw((xv + ((XW+1)'(1) <<< (SH-1))) >>> SH);
                r_s[k] <= clampw((yv + ((XW+1)'(1) <<< (SH-1))) >>> SH);
            end
        end
    end

    // stage A: cc, cs, delay the rest
    logic signed [OW-1:0] cc, cs;
    logic signed [OW-1:0] r_a_c [3];
    logic signed [OW-1:0] r_a_s [3];
    ezr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cc (
        .i_clk(i_clk), .i_en(en), .i_a(r_c[1]), .i_b(r_c[0]), .o_p(cc));
    ezr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cs (
        .i_clk(i_clk), .i_en(en), .i_a(r_c[1]), .i_b(r_s[0]), .o_p(cs));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_c <= r_c;
            r_a_s <= r_s;
        end
    end

    // stage B: twelve products
    logic signed [OW-1:0] pa [11];
    logic signed [OW-1:0] pb [11];
    logic signed [OW-1:0] pp [11];
    always_comb begin
        pa[0] = r_a_c[2]; pb[0] = cc;
        pa[1] = r_a_s[2]; pb[1] = r_a_s[0];
        pa[2] = r_a_c[2]; pb[2] = cs;
        pa[3] = r_a_s[2]; pb[3] = r_a_c[0];
        pa[4] = r_a_c[2]; pb[4] = r_a_s[1];
        pa[5] = r_a_s[2]; pb[5] = cc;
        pa[6] = r_a_c[2]; pb[6] = r_a_s[0];
        pa[7] = r_a_s[2]; pb[7] = cs;
        pa[8] = r_a_c[2]; pb[8] = r_a_c[0];
        pa[9] = r_a_s[2]; pb[9] = r_a_s[1];
        pa[10] = r_a_s[1]; pb[10] = r_a_c[0];
    end
    for (genvar g = 0; g < 11; g++) begin : g_mul
        ezr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(pa[g]), .i_b(pb[g]), .o_p(pp[g]));
    end
    logic signed [OW-1:0] m21p;
    logic signed [OW-1:0] r_b_cb;
    ezr_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_m21 (
        .i_clk(i_clk), .i_en(en), .i_a(r_a_s[1]), .i_b(r_a_s[0]), .o_p(m21p));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cb <= r_a_c[1];
        end
    end

    // stage C: sums and clamp
    function automatic logic signed [OW-1:0] clamps(input logic signed [OW+1:0] v);
        if (v > (OW+2)'(ONE)) clamps = ONE;
        else if (v < -(OW+2)'(ONE)) clamps = MONE;
        else clamps = OW'(v);
    endfunction
    logic signed [OW-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= clamps((OW+2)'(pp[0]) - (OW+2)'(pp[1]));
            r_m[1] <= clamps((OW+2)'(pp[2]) + (OW+2)'(pp[3]));
            r_m[2] <= clamps(-(OW+2)'(pp[4]));
            r_m[3] <= clamps(-(OW+2)'(pp[5]) - (OW+2)'(pp[6]));
            r_m[4] <= clamps(-(OW+2)'(pp[7]) + (OW+2)'(pp[8]));
            r_m[5] <= clamps((OW+2)'(pp[9]));
            r_m[6] <= clamps((OW+2)'(pp[10]));
            r_m[7] <= clamps((OW+2)'(m21p));
            r_m[8] <= r_b_cb;
        end
    end

    // final output register
    logic [OUTW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        logic [OUTW-1:0] v;
        v = '0;
        for (int k = 0; k < 9; k++) begin
            v[k*OW +: OW] = r_m[k];
        end
        if (en) begin
            r_out <= v;
        end
    end
    assign m_axis_tdata = r_out;

    `EZR_ASSERT_IMP(a_ready_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "ready while output held")
    `EZR_ASSERT_NEXT(a_hold_vld, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output item dropped")
    `EZR_ASSERT_NEXT(a_adv, s_axis_tvalid && s_axis_tready, r_vld[0], "accepted item not tracked")
endmodule
`default_nettype wire

[tb/sv/euler_zyz_checker.sv]
// Checker for the ZYZ Euler rotation matrix block: watches both stream channels,
// predicts each matrix with a bit-exact CORDIC model and compares element by element.
// Depends on nothing but the channel signals.
`timescale 1ns / 100ps
module euler_zyz_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [47:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [143:0] i_out_data,
    output int           o_errors,
    output int           o_pending
);
    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint GAIN = 64'sd652032874;

    longint atan_tab [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81,
        40, 20, 10, 5, 2, 1
    };

    logic [143:0] matrix_queue [$];

    function automatic longint round_q(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return round_q(a * b, FRAC);
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] t;
        logic flip;
        longint x, y, z, nx;
        t = {ang, 16'h0};
        flip = 1'b0;
        if (t[31] != t[30]) begin
            t[31] = ~t[31];
            flip = 1'b1;
        end
        z = longint'($signed(t));
        x = GAIN;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_unit(round_q(x, 30 - FRAC));
        s = clamp_unit(round_q(y, 30 - FRAC));
    endtask

    function automatic logic [15:0] elem(longint v);
        return 16'(clamp_unit(v));
    endfunction

    task automatic predict_matrix(input logic [47:0] angles, output logic [143:0] m);
        longint ca, sa, cb, sb, cg, sg, cc, cs;
        sin_cos(angles[15:0], ca, sa);
        sin_cos(angles[31:16], cb, sb);
        sin_cos(angles[47:32], cg, sg);
        cc = fmul(cb, ca);
        cs = fmul(cb, sa);
        m[15:0]    = elem(fmul(cg, cc) - fmul(sg, sa));
        m[31:16]   = elem(fmul(cg, cs) + fmul(sg, ca));
        m[47:32]   = elem(-fmul(cg, sb));
        m[63:48]   = elem(-fmul(sg, cc) - fmul(cg, sa));
        m[79:64]   = elem(-fmul(sg, cs) + fmul(cg, ca));
        m[95:80]   = elem(fmul(sg, sb));
        m[111:96]  = elem(fmul(sb, ca));
        m[127:112] = elem(fmul(sb, sa));
        m[143:128] = elem(cb);
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [143:0] m;
        logic [143:0] want;
        int bad;
        bad = 0;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            predict_matrix(i_in_data, m);
            matrix_queue.push_back(m);
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (matrix_queue.size() == 0) begin
                $display("%0t: unexpected matrix %h", $time, i_out_data);
                bad = bad + 1;
            end else begin
                want = matrix_queue.pop_front();
                for (int k = 0; k < 9; k++)
                    if (want[k*16 +: 16] != i_out_data[k*16 +: 16]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                                 $signed(want[k*16 +: 16]), $signed(i_out_data[k*16 +: 16]));
                        bad = bad + 1;
                    end
            end
        end
        if (bad != 0)
            o_errors <= o_errors + bad;
        o_pending <= matrix_queue.size();
    end
endmodule

[tb/sv/tb.sv]
// Testbench top for the ZYZ Euler rotation matrix block: drives angle triples
// under several idle and stall phases; checking is done by euler_zyz_checker.
// Depends on euler_zyz_rotation_matrix and euler_zyz_checker.
`timescale 1ns / 100ps
module tb;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [47:0]  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [143:0] m_data;
    int           errors;
    int           pending;
    int           send_idle = 0;
    int           recv_stall = 0;
    int           hold_off = 0;
    longint       cycles = 0;

    always #6 i_clk = ~i_clk;

    euler_zyz_rotation_matrix DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    euler_zyz_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'({$urandom_range(3), 14'h0} + $urandom_range(2) - 1);
            1: return 16'({$urandom_range(3), 14'h0});
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [47:0] angles);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= angles;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] corner [8];
        corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                   16'hFFFF, 16'h0001, 16'h3FFF, 16'h2000};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 8; i++)
            send_item({corner[(i + 5) % 8], corner[i], corner[(i + 2) % 8]});
        for (int i = 0; i < 8; i++)
            send_item({16'(i * 8192 + 1), 16'(16'hFFFF - i), 16'(i * 8192)});
        send_item({16'hAAAA, 16'h5555, 16'hFFFF});
        send_item({16'h5555, 16'hAAAA, 16'h0000});
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                3: begin send_idle = 7;  recv_stall = 7;  end
                default: begin send_idle = 0; recv_stall = 0; hold_off = 200; end
            endcase
            for (int n = 0; n < 380; n++)
                send_item({pick_angle(), pick_angle(), pick_angle()});
        end
        s_valid <= 1'b0;
        send_idle = 0;
        recv_stall = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[euler_zyz_rotation_matrix.f]
+incdir+hw/rtl
hw/rtl/ezr_pkg.sv
hw/rtl/ezr_cordic_cell.sv
hw/rtl/ezr_mul_cell.sv
hw/rtl/euler_zyz_rotation_matrix.sv
tb/sv/euler_zyz_checker.sv
tb/sv/tb.sv
